/* design/assert_macros.svh */
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LIS_ASSERT_IMP(lbl, clk, rstn, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define LIS_ASSERT_NXT(lbl, clk, rstn, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) else $error(msg);

`endif

/* design/lis_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_pkg
// Types, sizes and helpers shared by the longest increasing subsequence block.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int VALUE_BITS   = 16;
  localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int LEN_W        = 11;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 24;
  localparam int OUT_PAD_W    = OUT_DATA_W - 2 * LEN_W;
  localparam int RAM_W        = VALUE_BITS + CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } lis_state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } lis_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic scan_last;
    logic out_free;
  } lis_sts_t;

  function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] x);
    logic [CNT_W+LEN_W-1:0] w;
    w = {{LEN_W{1'b0}}, x};
    return w[LEN_W-1:0];
  endfunction

endpackage

/* design/lis_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/lis_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_datapath
// Element store, scan counter, running maximum and output word register.
// ----------------------------------------------------------------------------
module lis_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lis_pkg::lis_cmd_t                  cmd,
  output lis_pkg::lis_sts_t                  sts,
  input  logic [lis_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lis_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import lis_pkg::*;

  logic [VALUE_BITS-1:0] v_r;
  logic                  last_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      best_r, best_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [CNT_W-1:0]      longest_r, longest_nxt;
  logic                  rd_vld_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]      elem_out_r;
  logic [LEN_W-1:0]      best_out_r;
  logic                  ovf_r;
  logic                  seq_end_r;

  logic [RAM_W-1:0]          rd_data;
  logic [VALUE_BITS-1:0]     rd_val;
  logic [CNT_W-1:0]          rd_len;
  logic [VALUE_BITS+IN_DATA_W-1:0] v_ext;
  logic [CNT_W-1:0]          len;
  logic                      full;
  logic                      wr_en;

  assign v_ext  = {{VALUE_BITS{1'b0}}, in_tdata};
  assign rd_val = rd_data[VALUE_BITS-1:0];
  assign rd_len = rd_data[RAM_W-1:VALUE_BITS];
  assign full   = (count_r == CNT_W'(MAX_ELEMENTS));
  assign len    = longest_r + CNT_W'(1);
  assign wr_en  = cmd.commit && !full;

  assign sts.empty     = (count_r == '0);
  assign sts.full      = full;
  assign sts.scan_last = (k_r == count_r - CNT_W'(1));
  assign sts.out_free  = !out_valid_r || out_tready;

  lis_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_r[ADDR_W-1:0]),
    .wr_data({len, v_r}),
    .rd_en  (cmd.issue),
    .rd_addr(k_r[ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  always_comb begin
    k_nxt         = k_r;
    longest_nxt   = longest_r;
    count_nxt     = count_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.load) begin
      k_nxt       = '0;
      longest_nxt = '0;
    end
    if (cmd.issue) begin
      k_nxt = k_r + CNT_W'(1);
    end
    if (rd_vld_r && (rd_val < v_r) && (rd_len > longest_r)) begin
      longest_nxt = rd_len;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      if (!full) begin
        count_nxt = count_r + CNT_W'(1);
        if (len > best_r) begin
          best_nxt = len;
        end
      end
      if (last_r) begin
        count_nxt = '0;
        best_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      best_r      <= '0;
      k_r         <= '0;
      longest_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      best_r      <= best_nxt;
      k_r         <= k_nxt;
      longest_r   <= longest_nxt;
      rd_vld_r    <= cmd.issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r    <= v_ext[VALUE_BITS-1:0];
      last_r <= in_tlast;
    end
    if (cmd.commit) begin
      elem_out_r <= full ? '0 : to_len(len);
      best_out_r <= (!full && (len > best_r)) ? to_len(len) : to_len(best_r);
      ovf_r      <= full;
      seq_end_r  <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), best_out_r, elem_out_r};
  assign out_tuser  = ovf_r;
  assign out_tlast  = seq_end_r;

endmodule

/* design/lis_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_ctrl
// Sequencer: accept a word, scan the store, drain the read, commit the result;
// the scan and drain are skipped when the store is empty or full.
module lis_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lis_pkg::lis_sts_t sts,
  output lis_pkg::lis_cmd_t cmd
);
  import lis_pkg::*;

  lis_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts.empty || sts.full) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/longest_increasing_subsequence.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_increasing_subsequence
// A word is accepted in ST_IDLE; the store is scanned in ST_SCAN, the last read
// is drained in ST_DRAIN and the result is committed in ST_FIN. An empty or full
// store skips ST_SCAN and ST_DRAIN. The next word is accepted after the commit.
// Rate is set by the scan of the element store, one read port, one entry a cycle.
// Reset clears the sequencer, counts, best length and output valid; the store
// is not cleared, as only entries written in the current sequence are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module longest_increasing_subsequence (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lis_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] value
  input  logic                           in_tlast,   // last_item
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lis_pkg::OUT_DATA_W-1:0] out_tdata,  // [10:0] element_length,
                                                     // [21:11] best_length
  output logic                           out_tuser,  // overflow
  output logic                           out_tlast   // sequence_end
);
  import lis_pkg::*;

  lis_cmd_t cmd;
  lis_sts_t sts;
  logic     in_accept;
  logic     elem_zero;
  logic     len_ok;

  lis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lis_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  assign in_accept = in_tvalid && in_tready;
  assign elem_zero = (out_tdata[LEN_W-1:0] == '0);
  assign len_ok    = !elem_zero && (out_tdata[LEN_W-1:0] <= out_tdata[2*LEN_W-1:LEN_W]);

  `LIS_ASSERT_NXT(a_accept_busy, clk, rst_n, in_accept, !in_tready, "ready after accept")
  `LIS_ASSERT_IMP(a_ovf_zero, clk, rst_n, out_tvalid && out_tuser, elem_zero, "length on overflow")
  `LIS_ASSERT_IMP(a_len_bound, clk, rst_n, out_tvalid && !out_tuser, len_ok, "bad element length")

endmodule

/* bench/lis_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_checker
// Watches the input and result streams of the longest increasing subsequence
// block. Keeps its own element store per sequence, works out the result word
// due for every accepted input word and compares the result words in order.
// ----------------------------------------------------------------------------
module lis_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [lis_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] value
  input  logic                           in_tlast,   // last_item
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [lis_pkg::OUT_DATA_W-1:0] out_tdata,  // [10:0] element_length,
                                                     // [21:11] best_length
  input  logic                           out_tuser,  // overflow
  input  logic                           out_tlast,  // sequence_end
  output int                             error_count,
  output int                             pending_words
);

  localparam int LW = lis_pkg::LEN_W;

  typedef struct packed {
    logic [LW-1:0] elem_len;
    logic [LW-1:0] best_len;
    logic          overflow;
    logic          seq_end;
  } lis_word_t;

  logic [lis_pkg::VALUE_BITS-1:0] seq_value [lis_pkg::MAX_ELEMENTS];
  logic [LW-1:0]                  seq_len   [lis_pkg::MAX_ELEMENTS];
  int                             seq_count;
  int                             seq_best;
  lis_word_t                      expected_q [$];

  function automatic lis_word_t extend_sequence(
    input logic [lis_pkg::VALUE_BITS-1:0] value,
    input logic                           last
  );
    lis_word_t w;
    int        longest;
    int        k;
    w = '0;
    if (seq_count >= lis_pkg::MAX_ELEMENTS) begin
      w.overflow = 1'b1;
    end else begin
      longest = 0;
      for (k = 0; k < seq_count; k++) begin
        if (seq_value[k] < value && int'(seq_len[k]) > longest) begin
          longest = int'(seq_len[k]);
        end
      end
      seq_value[seq_count] = value;
      seq_len[seq_count]   = LW'(longest + 1);
      seq_count++;
      w.elem_len = LW'(longest + 1);
      if (longest + 1 > seq_best) begin
        seq_best = longest + 1;
      end
    end
    w.best_len = LW'(seq_best);
    w.seq_end  = last;
    // close the sequence; stored entries stay as they are
    if (last) begin
      seq_count = 0;
      seq_best  = 0;
    end
    return w;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    lis_word_t want;
    if (!rst_n) begin
      seq_count   = 0;
      seq_best    = 0;
      error_count = 0;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result word, expected none, actual %h %b %b",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          want = expected_q.pop_front();
          check_field("element_length", int'(want.elem_len), int'(out_tdata[LW-1:0]));
          check_field("best_length", int'(want.best_len), int'(out_tdata[2*LW-1:LW]));
          check_field("overflow", int'(want.overflow), int'(out_tuser));
          check_field("sequence_end", int'(want.seq_end), int'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        expected_q.push_back(extend_sequence(in_tdata[lis_pkg::VALUE_BITS-1:0], in_tlast));
      end
    end
    pending_words = expected_q.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sequences of values into the longest increasing subsequence block:
// a directed set of corner values, random sequences of varied shape, one
// sequence that fills the element store and runs past it, and a long hold on
// the result side. Result words are checked by lis_checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_PERIOD   = 4;
  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_ITEMS  = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 32;
  localparam int RAMP_STEP    = 65536 / lis_pkg::MAX_ELEMENTS;

  typedef enum int {
    MODE_RANDOM,
    MODE_FEW,
    MODE_RAMP,
    MODE_CORNER
  } content_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [lis_pkg::IN_DATA_W-1:0]  in_tdata   = '0;  // [15:0] value
  logic                           in_tlast   = 1'b0; // last_item
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [lis_pkg::OUT_DATA_W-1:0] out_tdata;         // [10:0] element_length,
                                                     // [21:11] best_length
  logic                           out_tuser;         // overflow
  logic                           out_tlast;         // sequence_end
  int                             error_count;
  int                             pending_words;
  int                             idle_cycles = 0;
  bit                             idle_on     = 1'b0;
  bit                             hold_req    = 1'b0;
  bit                             hold_done   = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  longest_increasing_subsequence u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  lis_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .error_count   (error_count),
    .pending_words (pending_words)
  );

  task automatic send_word(input logic [15:0] value, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // receiver: random stalls, plus one long hold on request
  always begin
    @(posedge clk);
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      out_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int          sent;
    int          seq_items;
    int          k;
    bit          long_done;
    content_t    mode;
    logic [15:0] v;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-word sequences at both value extremes
    send_word(16'hFFFF, 1'b1);
    send_word(16'h0000, 1'b1);
    // equal values, steps up and down, top value last
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFE, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0005, 1'b0);
    send_word(16'hFFFF, 1'b1);
    // strictly decreasing, then a two-word rising sequence
    send_word(16'hFFFF, 1'b0);
    send_word(16'hAAAA, 1'b0);
    send_word(16'h5555, 1'b0);
    send_word(16'h0000, 1'b1);
    send_word(16'h5555, 1'b0);
    send_word(16'hAAAA, 1'b1);

    sent      = 0;
    long_done = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = (sent < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
      if (!long_done && sent >= 150) begin
        long_done = 1'b1;
        // fill the store with a strictly rising run, then overflow it
        for (k = 0; k < lis_pkg::MAX_ELEMENTS; k++) begin
          send_word(16'(k * RAMP_STEP + $urandom_range(0, RAMP_STEP - 1)), 1'b0);
        end
        seq_items = $urandom_range(1, 4);
        for (k = 0; k < seq_items; k++) begin
          send_word(16'($urandom), k == seq_items - 1);
        end
      end else begin
        seq_items = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                : $urandom_range(1, 16);
        mode = content_t'($urandom_range(0, 3));
        for (k = 0; k < seq_items; k++) begin
          case (mode)
            MODE_RANDOM: v = 16'($urandom);
            MODE_FEW:    v = 16'($urandom_range(0, 7));
            MODE_RAMP:   v = 16'(k * 300 + $urandom_range(0, 600));
            default: begin
              case ($urandom_range(0, 3))
                0:       v = 16'h0000;
                1:       v = 16'hFFFF;
                2:       v = 16'h7FFF;
                default: v = 16'h8000;
              endcase
            end
          endcase
          if (sent == 60) begin
            hold_req = 1'b1;
          end
          send_word(v, k == seq_items - 1);
          sent++;
        end
      end
    end
    in_tvalid <= 1'b0;
    idle_on = 1'b0;

    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/lis_pkg.sv
design/lis_ram.sv
design/lis_datapath.sv
design/lis_ctrl.sv
design/longest_increasing_subsequence.sv
bench/lis_checker.sv
bench/testbench.sv
